@@ rtl/gost_pkg.sv @@
// shared types, constants and round functions for the gost block cipher core
// no dependencies; imported by gost_stage, the top level and the testbench files
package gost_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int NUM_ROWS   = 8;
    localparam int POS_W      = $clog2(NUM_ROUNDS);
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int ROT_AMT    = 11;

    // round position at which the key order turns from ascending to descending
    localparam logic [POS_W-1:0] SPLIT_ENC = POS_W'(24);
    localparam logic [POS_W-1:0] SPLIT_DEC = POS_W'(8);

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef logic [31:0]               word_t;
    typedef logic [63:0]               sbox_row_t;
    typedef logic [NUM_ROWS-1:0][63:0] sbox_set_t;
    typedef logic [7:0][31:0]          key_sched_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [ROW_W-1:0]          row_sel_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    typedef struct packed {
        logic       func;
        word_t      n1;
        word_t      n2;
        key_sched_t key;
    } gost_item_t;

    // key word and s-box row used at a given round position
    function automatic row_sel_t round_sel(input pos_t pos, input logic func);
        pos_t split;
        split = (func == FUNC_DECRYPT) ? SPLIT_DEC : SPLIT_ENC;
        if (pos < split)
            return pos[ROW_W-1:0];
        else
            return ~pos[ROW_W-1:0];
    endfunction

    // every nibble of the word goes through the same row
    function automatic word_t substitute(input word_t x, input sbox_row_t row);
        word_t y;
        y = '0;
        for (int n = 0; n < 8; n++)
        begin
            y[4*n +: 4] = row[4*x[4*n +: 4] +: 4];
        end
        return y;
    endfunction

endpackage

@@ rtl/gost_if.sv @@
// valid/ready channel interfaces for input blocks and result blocks
// no dependencies; field widths are written out as literals
interface gost_in_if;
    logic  valid;
    logic  ready;
    logic  func;
    logic [63:0] data_block;
    logic [63:0] key_words_0_1;
    logic [63:0] key_words_2_3;
    logic [63:0] key_words_4_5;
    logic [63:0] key_words_6_7;

    modport source (
        output valid, func, data_block,
               key_words_0_1, key_words_2_3, key_words_4_5, key_words_6_7,
        input  ready
    );
    modport sink (
        input  valid, func, data_block,
               key_words_0_1, key_words_2_3, key_words_4_5, key_words_6_7,
        output ready
    );
endinterface

interface gost_out_if;
    logic  valid;
    logic  ready;
    logic [63:0] result_block;

    modport source (
        output valid, result_block,
        input  ready
    );
    modport sink (
        input  valid, result_block,
        output ready
    );
endinterface

@@ rtl/gost_stage.sv @@
// one feistel round with its pipeline register and valid bit
// depends on gost_pkg (item type, round_sel, substitute)
module gost_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gost_pkg::pos_t         pos,
    input  gost_pkg::sbox_set_t    sbox,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  gost_pkg::gost_item_t   up_item,
    output logic                   down_valid,
    input  logic                   down_ready,
    output gost_pkg::gost_item_t   down_item
);
    import gost_pkg::*;

    logic       valid_reg;
    gost_item_t item_reg;
    gost_item_t item_next;
    row_sel_t   sel;
    word_t      t_sum;
    word_t      t_sub;

    // stage takes a beat when empty or when its contents move on
    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_item  = item_reg;

    always_comb
    begin
        sel       = round_sel(pos, up_item.func);
        t_sum     = up_item.n1 + up_item.key[sel];
        t_sub     = substitute(t_sum, sbox[sel]);
        item_next = up_item;
        item_next.n1 = {t_sub[31-ROT_AMT:0], t_sub[31:32-ROT_AMT]} ^ up_item.n2;
        item_next.n2 = up_item.n1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

endmodule

@@ rtl/gost_block_cipher_core.sv @@
// gost block cipher core: 32 unrolled feistel rounds, one register stage per round
// throughput one block per cycle when the result channel is not stalled, set by the
// one-round-per-stage pipeline; each stage holds under back-pressure
// reset clears all stage valid bits and the eight s-box rows to zero
// depends on gost_pkg, gost_if and gost_stage
module gost_block_cipher_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  gost_pkg::cfg_idx_t    cfg_index,
    input  logic [63:0]           cfg_wdata,
    gost_in_if.sink               data_chan,
    gost_out_if.source            result_chan
);
    import gost_pkg::*;

    sbox_set_t  sbox_reg;

    logic       stage_valid [NUM_ROUNDS+1];
    logic       stage_ready [NUM_ROUNDS+1];
    gost_item_t stage_item  [NUM_ROUNDS+1];

    // s-box rows; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sbox_reg <= '0;
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_ROWS)))
            sbox_reg[cfg_index[ROW_W-1:0]] <= cfg_wdata;
    end

    // slot zero is the input channel
    assign stage_valid[0]       = data_chan.valid;
    assign data_chan.ready      = stage_ready[0];
    assign stage_item[0].func   = data_chan.func;
    assign stage_item[0].n1     = data_chan.data_block[63:32];
    assign stage_item[0].n2     = data_chan.data_block[31:0];
    assign stage_item[0].key[0] = data_chan.key_words_0_1[63:32];
    assign stage_item[0].key[1] = data_chan.key_words_0_1[31:0];
    assign stage_item[0].key[2] = data_chan.key_words_2_3[63:32];
    assign stage_item[0].key[3] = data_chan.key_words_2_3[31:0];
    assign stage_item[0].key[4] = data_chan.key_words_4_5[63:32];
    assign stage_item[0].key[5] = data_chan.key_words_4_5[31:0];
    assign stage_item[0].key[6] = data_chan.key_words_6_7[63:32];
    assign stage_item[0].key[7] = data_chan.key_words_6_7[31:0];

    for (genvar p = 0; p < NUM_ROUNDS; p++)
    begin : g_round
        gost_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .pos        (POS_W'(p)),
            .sbox       (sbox_reg),
            .up_valid   (stage_valid[p]),
            .up_ready   (stage_ready[p]),
            .up_item    (stage_item[p]),
            .down_valid (stage_valid[p+1]),
            .down_ready (stage_ready[p+1]),
            .down_item  (stage_item[p+1])
        );
    end

    // last round register doubles as the output register; halves go out swapped
    assign stage_ready[NUM_ROUNDS] = result_chan.ready;
    assign result_chan.valid       = stage_valid[NUM_ROUNDS];
    assign result_chan.result_block = {stage_item[NUM_ROUNDS].n2, stage_item[NUM_ROUNDS].n1};

endmodule

@@ dv/gost_block_cipher_checker.sv @@
// checker for the gost block cipher core: mirrors the s-box registers from the
// config port, predicts each result block and compares it on the result channel
// depends on gost_pkg and the gost_in_if / gost_out_if interfaces
module gost_block_cipher_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  gost_pkg::cfg_idx_t cfg_index,
    input  logic [63:0]        cfg_wdata,
    gost_in_if                 blocks_in,
    gost_out_if                blocks_out,
    input  logic               drain_check,
    output int                 in_flight,
    output int                 error_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import gost_pkg::*;

    sbox_row_t   sbox_copy [NUM_ROWS];
    logic [63:0] expected_blocks [$];
    int          mismatches = 0;
    int          beats_seen = 0;
    bit          drained = 1'b0;

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // each nibble indexes the row directly, entry v at bits 4v+3..4v
    function automatic word_t sbox_lookup(input word_t w, input sbox_row_t tbl);
        word_t    y;
        logic [3:0] nib;
        y = '0;
        for (int k = 0; k < 8; k++)
        begin
            nib = w[4*k +: 4];
            y[4*k +: 4] = tbl[{nib, 2'b00} +: 4];
        end
        return y;
    endfunction

    function automatic logic [63:0] cipher_block(
        input logic        op,
        input logic [63:0] blk,
        input logic [63:0] k01,
        input logic [63:0] k23,
        input logic [63:0] k45,
        input logic [63:0] k67
    );
        word_t kw [8];
        word_t left;
        word_t right;
        word_t t;
        int    ascend;
        int    r;
        kw[0] = k01[63:32];
        kw[1] = k01[31:0];
        kw[2] = k23[63:32];
        kw[3] = k23[31:0];
        kw[4] = k45[63:32];
        kw[5] = k45[31:0];
        kw[6] = k67[63:32];
        kw[7] = k67[31:0];
        ascend = (op == FUNC_DECRYPT) ? int'(SPLIT_DEC) : int'(SPLIT_ENC);
        left = blk[63:32];
        right = blk[31:0];
        for (int step = 0; step < NUM_ROUNDS; step++)
        begin
            // ascending rounds first, then the remainder counted down from the top
            r = (step < ascend) ? step : (NUM_ROUNDS - 1 - (step - ascend));
            t = left + kw[r % 8];
            t = sbox_lookup(t, sbox_copy[r % 8]);
            t = {t[31-ROT_AMT:0], t[31:32-ROT_AMT]};
            t = t ^ right;
            right = left;
            left = t;
        end
        return {right, left};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
                sbox_copy[i] = '0;
            expected_blocks.delete();
            in_flight <= 0;
            error_count <= mismatches;
        end
        else
        begin
            // indices past the last row are dropped by the block
            if (cfg_we && cfg_index < NUM_ROWS)
                sbox_copy[cfg_index] = cfg_wdata;

            if (blocks_in.valid && blocks_in.ready)
                expected_blocks.push_back(cipher_block(blocks_in.func,
                    blocks_in.data_block, blocks_in.key_words_0_1,
                    blocks_in.key_words_2_3, blocks_in.key_words_4_5,
                    blocks_in.key_words_6_7));

            if (blocks_out.valid && blocks_out.ready)
            begin
                beats_seen++;
                if (expected_blocks.size() == 0)
                    report_mismatch($sformatf("result beat %0d (%h) with nothing expected",
                        beats_seen, blocks_out.result_block));
                else if (blocks_out.result_block !== expected_blocks[0])
                begin
                    report_mismatch($sformatf("result beat %0d result_block %h, expected %h",
                        beats_seen, blocks_out.result_block, expected_blocks[0]));
                    void'(expected_blocks.pop_front());
                end
                else
                    void'(expected_blocks.pop_front());
            end

            if (drain_check && !drained)
            begin
                drained = 1'b1;
                foreach (expected_blocks[i])
                    report_mismatch($sformatf("expected result %h never arrived",
                        expected_blocks[i]));
                expected_blocks.delete();
            end

            in_flight <= expected_blocks.size();
            error_count <= mismatches;
        end
    end

endmodule

@@ dv/gost_block_cipher_core_test.sv @@
// top of the gost block cipher core testbench: clock, reset, s-box programming,
// block stimulus with varied source/sink idling; checking lives in gost_block_cipher_checker
// depends on gost_pkg, gost_if, gost_block_cipher_core and gost_block_cipher_checker
module gost_block_cipher_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gost_pkg::*;

    localparam int RANDOM_PER_PHASE = 222;
    localparam int NUM_PHASES       = 8;

    typedef enum int
    {
        ROWS_ZERO,
        ROWS_ONES,
        ROWS_IDENTITY,
        ROWS_PERMUTED,
        ROWS_RANDOM,
        ROWS_STRIPED
    } row_fill_e;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    logic [63:0] cfg_wdata;
    logic     end_check;
    int       in_flight;
    int       error_count;
    int       src_idle_pct;
    int       sink_stall_pct;

    gost_in_if  data_ch ();
    gost_out_if result_ch ();

    gost_block_cipher_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .data_chan   (data_ch),
        .result_chan (result_ch)
    );

    gost_block_cipher_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .blocks_in   (data_ch),
        .blocks_out  (result_ch),
        .drain_check (end_check),
        .in_flight   (in_flight),
        .error_count (error_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        result_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] pick_word64();
        case ($urandom_range(15))
            0:       return 64'h0;
            1:       return '1;
            2:       return {$urandom, 32'hFFFF_FFFF};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic sbox_row_t shuffled_row();
        logic [3:0] vals [16];
        logic [3:0] tmp;
        sbox_row_t  row;
        int         j;
        for (int i = 0; i < 16; i++)
            vals[i] = 4'(i);
        for (int i = 15; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
        for (int i = 0; i < 16; i++)
            row[4*i +: 4] = vals[i];
        return row;
    endfunction

    function automatic sbox_row_t fill_row(input row_fill_e fill, input int idx);
        case (fill)
            ROWS_ZERO:     return '0;
            ROWS_ONES:     return '1;
            ROWS_IDENTITY: return 64'hFEDC_BA98_7654_3210;
            ROWS_PERMUTED: return shuffled_row();
            ROWS_STRIPED:  return (idx % 2 == 1) ? '1 : shuffled_row();
            default:       return {$urandom, $urandom};
        endcase
    endfunction

    // hold the source off until the pipeline has emptied
    task automatic wait_idle();
        data_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
    endtask

    // all eight rows, then one stray write to an index past the last row
    task automatic program_rows(input row_fill_e fill);
        wait_idle();
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_wdata <= fill_row(fill, i);
            @(posedge clk);
        end
        cfg_index <= cfg_idx_t'($urandom_range(15, NUM_ROWS));
        cfg_wdata <= {$urandom, $urandom};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_block(
        input logic        op,
        input logic [63:0] blk,
        input logic [63:0] k01,
        input logic [63:0] k23,
        input logic [63:0] k45,
        input logic [63:0] k67
    );
        data_ch.valid <= 1'b1;
        data_ch.func <= op;
        data_ch.data_block <= blk;
        data_ch.key_words_0_1 <= k01;
        data_ch.key_words_2_3 <= k23;
        data_ch.key_words_4_5 <= k45;
        data_ch.key_words_6_7 <= k67;
        do
            @(posedge clk);
        while (!data_ch.ready);
        // idle cycles carry junk on the data bus
        while ($urandom_range(99) < src_idle_pct)
        begin
            data_ch.valid <= 1'b0;
            data_ch.data_block <= {$urandom, $urandom};
            @(posedge clk);
        end
    endtask

    task automatic send_random_block();
        send_block($urandom_range(1) ? FUNC_DECRYPT : FUNC_ENCRYPT, pick_word64(),
            pick_word64(), pick_word64(), pick_word64(), pick_word64());
    endtask

    initial
    begin
        row_fill_e phase_fill [NUM_PHASES];
        logic [63:0] patterns [4];
        logic        op;

        phase_fill = '{ROWS_PERMUTED, ROWS_RANDOM, ROWS_ONES, ROWS_STRIPED,
                       ROWS_IDENTITY, ROWS_PERMUTED, ROWS_ZERO, ROWS_RANDOM};
        patterns = '{64'h0, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        end_check = 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        data_ch.valid = 1'b0;
        data_ch.func = FUNC_ENCRYPT;
        data_ch.data_block = '0;
        data_ch.key_words_0_1 = '0;
        data_ch.key_words_2_3 = '0;
        data_ch.key_words_4_5 = '0;
        data_ch.key_words_6_7 = '0;
        result_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // s-box rows straight out of reset are all zero
        send_block(FUNC_ENCRYPT, 64'h0123_4567_89AB_CDEF, '0, '0, '0, '0);
        send_block(FUNC_DECRYPT, '1, '1, '1, '1, '1);

        program_rows(ROWS_PERMUTED);
        for (int p = 0; p < 4; p++)
        begin
            op = (p % 2 == 1) ? FUNC_DECRYPT : FUNC_ENCRYPT;
            send_block(op, patterns[p], patterns[3 - p], patterns[p], patterns[3 - p],
                patterns[p]);
            send_block(~op, patterns[p], patterns[p], patterns[3 - p], patterns[p],
                patterns[3 - p]);
        end
        // left half plus key word wraps past 2^32
        send_block(FUNC_ENCRYPT, 64'hFFFF_FFFF_0000_0000, '1, '1, '1, '1);
        send_block(FUNC_DECRYPT, 64'hFFFF_FFFF_0000_0001, 64'h0000_0001_FFFF_FFFF,
            '1, '1, '1);
        // distinct key words show which word each round picks
        send_block(FUNC_ENCRYPT, 64'h0, 64'h0000_0001_0000_0002, 64'h0000_0004_0000_0008,
            64'h0000_0010_0000_0020, 64'h0000_0040_0000_0080);
        send_block(FUNC_DECRYPT, 64'h0, 64'h0000_0001_0000_0002, 64'h0000_0004_0000_0008,
            64'h0000_0010_0000_0020, 64'h0000_0040_0000_0080);

        // odd rows all ones, even rows permuted: one shared row per round shows up
        program_rows(ROWS_STRIPED);
        send_block(FUNC_ENCRYPT, 64'h0123_4567_89AB_CDEF, 64'h0, 64'h0, 64'h0, 64'h0);
        send_block(FUNC_DECRYPT, 64'hFEDC_BA98_7654_3210, 64'h1111_2222_3333_4444,
            64'h5555_6666_7777_8888, 64'h9999_AAAA_BBBB_CCCC, 64'hDDDD_EEEE_FFFF_0000);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            program_rows(phase_fill[ph]);
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 71; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 71; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n == RANDOM_PER_PHASE / 2)
                    wait_idle();
                send_random_block();
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
